// ===== hw/rtl/bcdt_pkg.sv =====
package bcdt_pkg;

  // action selected by the side-band of an input item
  typedef enum logic [2:0] {
    MODE_SECOND  = 3'd0,
    MODE_MINUTE  = 3'd1,
    MODE_HOUR    = 3'd2,
    MODE_DAY     = 3'd3,
    MODE_MONTH   = 3'd4,
    MODE_YEAR    = 3'd5,
    MODE_WEEKDAY = 3'd6
  } mode_t;

  // packed-bcd calendar record, narrowed to the bits each field can use
  typedef struct packed {
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } rec_t;

  localparam logic [7:0] SEC_LIMIT  = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;
  localparam logic [7:0] YEAR_LIMIT = 8'd100;
  localparam logic [7:0] MONTH_MAX  = 8'd12;
  localparam logic [7:0] DOW_BASE   = 8'd6;
  localparam logic [7:0] DOW_MOD    = 8'd7;

  localparam rec_t REC_RESET = '{
    year: 8'h00, month: 5'h01, day: 6'h01, weekday: 3'd6,
    hour: 6'h00, minute: 7'h00, second: 7'h00
  };

  // binary 0..99 to packed bcd, tens by reciprocal multiply (v*205 >> 11)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  function automatic logic [6:0] from_bcd(input logic [7:0] b);
    return 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mi);
    logic [4:0] len;
    case (mi)
      4'd1:                    len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_off(input logic [3:0] mi);
    logic [2:0] off;
    case (mi)
      4'd0:  off = 3'd0;
      4'd1:  off = 3'd3;
      4'd2:  off = 3'd3;
      4'd3:  off = 3'd6;
      4'd4:  off = 3'd1;
      4'd5:  off = 3'd4;
      4'd6:  off = 3'd6;
      4'd7:  off = 3'd2;
      4'd8:  off = 3'd5;
      4'd9:  off = 3'd0;
      4'd10: off = 3'd3;
      4'd11: off = 3'd5;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== hw/rtl/bcdt_calc.sv =====
module bcdt_calc import bcdt_pkg::*; (
  input  rec_t       cur,
  input  mode_t      mode,
  input  logic [7:0] value,
  output rec_t       nxt
);

  logic [6:0] sec_bin, hour_bin, year_bin;
  logic [3:0] month_bin;
  logic [6:0] m_cur, y_cur, d_cur;
  logic [3:0] mi;
  logic       leap_cur, leap_new;
  logic [4:0] last_cur, last_new;
  logic [4:0] day_set, day_recheck;
  logic [7:0] dow_sum;
  logic [14:0] dow_prod;
  logic [7:0] dow_rem;
  logic [2:0] dow;

  assign sec_bin  = (value >= SEC_LIMIT)  ? 7'd0 : value[6:0];
  assign hour_bin = (value >= HOUR_LIMIT) ? 7'd0 : value[6:0];
  assign year_bin = (value >= YEAR_LIMIT) ? 7'd0 : value[6:0];

  always_comb begin
    if (value == 8'd0) begin
      month_bin = 4'(MONTH_MAX);
    end else if (value > MONTH_MAX) begin
      month_bin = 4'd1;
    end else begin
      month_bin = value[3:0];
    end
  end

  assign m_cur = from_bcd({3'b000, cur.month});
  assign y_cur = from_bcd(cur.year);
  assign d_cur = from_bcd({2'b00, cur.day});

  // month index 0..11, anything out of range reads as january
  assign mi = (m_cur < 7'd1 || m_cur > 7'd12) ? 4'd0 : 4'(m_cur - 7'd1);

  assign leap_cur = (y_cur[1:0] == 2'b00);
  assign leap_new = (year_bin[1:0] == 2'b00);
  assign last_cur = month_len(mi) + 5'((mi == 4'd1) && leap_cur);
  assign last_new = month_len(mi) + 5'((mi == 4'd1) && leap_new);

  always_comb begin
    if (value == 8'd0) begin
      day_set = last_cur;
    end else if (value > {3'b000, last_cur}) begin
      day_set = 5'd1;
    end else begin
      day_set = value[4:0];
    end
  end

  always_comb begin
    if (d_cur == 7'd0) begin
      day_recheck = last_new;
    end else if (d_cur > {2'b00, last_new}) begin
      day_recheck = 5'd1;
    end else begin
      day_recheck = d_cur[4:0];
    end
  end

  // weekday: sum then mod 7 via q = sum*73 >> 9 and one correction
  assign dow_sum = DOW_BASE + 8'(y_cur) + 8'(y_cur[6:2]) + 8'(month_off(mi)) + 8'(d_cur)
                 - 8'(leap_cur && (mi < 4'd2));
  assign dow_prod = 15'(dow_sum) * 15'd73;
  assign dow_rem  = dow_sum - 8'(dow_prod[14:9]) * DOW_MOD;
  assign dow      = (dow_rem >= DOW_MOD) ? 3'(dow_rem - DOW_MOD) : dow_rem[2:0];

  always_comb begin
    nxt = cur;
    unique case (mode)
      MODE_SECOND:  nxt.second  = 7'(to_bcd(sec_bin));
      MODE_MINUTE:  nxt.minute  = 7'(to_bcd(sec_bin));
      MODE_HOUR:    nxt.hour    = 6'(to_bcd(hour_bin));
      MODE_DAY:     nxt.day     = 6'(to_bcd({2'b00, day_set}));
      MODE_MONTH:   nxt.month   = 5'(to_bcd({3'b000, month_bin}));
      MODE_YEAR: begin
        nxt.year = to_bcd(year_bin);
        nxt.day  = 6'(to_bcd({2'b00, day_recheck}));
      end
      MODE_WEEKDAY: nxt.weekday = dow;
      default:      nxt = cur;
    endcase
  end

endmodule

// ===== hw/rtl/bcd_date_time_setter_weekday_top.sv =====
// packed-bcd date/time record (years 2000..2099) with field setters and weekday
//
// input stream: each item sets one field from a binary value (s_tdata) under
// the action in s_tuser, or asks for the weekday; out-of-range values wrap
// output stream: one item per input item, carrying the whole record after the
// update, in the order the inputs were taken
// path: from input handshake the item is taken into the input register, and is then
// loaded into the record register, which also serves as the result register and
// drives m_tvalid
// throughput: one item per cycle while m_tready is high; the record update is a single shallow pass
// of logic from the input register, so each item sees the previous one's result
// stall: while m_tready is low the pending result holds, one more input item
// may sit in the input register, and s_tready drops once both are full
// reset (rst, synchronous): both stages empty, record set to 00:00:00,
// day 01, month 01, year 00, weekday 6 (saturday)
module bcd_date_time_setter_weekday_top import bcdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] value
  input  logic [2:0]  s_tuser,   // [2:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [6:0] second, [13:7] minute, [19:14] hour,
                                 // [22:20] weekday, [28:23] day, [33:29] month,
                                 // [41:34] year, [47:42] zero
);

  // input register
  logic       in_valid;
  mode_t      in_mode;
  logic [7:0] in_value;

  // record register, shown on the output while out_valid
  rec_t rec;
  rec_t rec_next;
  logic out_valid;

  // an item moves into the record when the result slot is free or being taken
  logic advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  bcdt_calc u_calc (
    .cur   (rec),
    .mode  (in_mode),
    .value (in_value),
    .nxt   (rec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode  <= mode_t'(s_tuser);
      in_value <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec       <= REC_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      rec       <= rec_next;
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, rec.year, rec.month, rec.day, rec.weekday,
                     rec.hour, rec.minute, rec.second};

`ifndef SYNTHESIS
  // record never changes while a result waits to be taken
  a_hold_rec: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> $stable(rec))
    else $error("record changed during output stall");

  // an accepted item always lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted item lost");

  // month and day stay nonzero and within 12h and 31h, weekday in range
  a_rec_legal: assert property (@(posedge clk) disable iff (rst)
    rec.month != 5'h00 && rec.month <= 5'h12 && rec.day != 6'h00 && rec.day <= 6'h31
    && rec.weekday != 3'd7)
    else $error("record holds an illegal value");

  // record only changes when an item advances
  a_rec_update: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(rec))
    else $error("record changed without an item");
`endif

endmodule
